// File: sv/pcm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types and constants of the partition code matcher.
// ----------------------------------------------------------------------------
package pcm_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int CODE_BITS   = 16;

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int DIST_W = 5;
   localparam int FIX_W  = 5;
   localparam int COST_W = 16;
   localparam int TAG_W  = 6;
   localparam int MIDX_W = 6;
   localparam int CW_W   = 5;
   localparam int KEY_W  = 16;

   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [KEY_W-1:0]  entry_code;
      logic [COST_W-1:0] entry_cost;
      logic [FIX_W-1:0]  fixed_bit;
      logic [TAG_W-1:0]  query_tag;
      logic [KEY_W-1:0]  query_key;
   } pcm_req_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag_out;
      logic              found;
      logic [MIDX_W-1:0] match_index;
      logic              inverse;
      logic              exact;
      logic [DIST_W-1:0] distance;
      logic [COST_W-1:0] total_cost;
   } pcm_rsp_type;

   // one table entry as held in the memory
   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      logic [COST_W-1:0]    cost;
      logic [FIX_W-1:0]     fixed;
   } pcm_entry_type;

   // scan control that travels alongside the memory read data
   typedef struct packed {
      logic             valid;
      logic             first;
      logic [IDX_W-1:0] index;
   } pcm_scan_type;

   // winner of a finished scan
   typedef struct packed {
      logic              exact;
      logic [IDX_W-1:0]  index;
      logic              inverse;
      logic [DIST_W-1:0] distance;
      logic [COST_W-1:0] total_cost;
   } pcm_pick_type;

endpackage

// File: sv/pcm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/pcm_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_eval
// Compares one table entry per cycle with the query key and keeps both the
// best exact match and the nearest match seen so far.
// ----------------------------------------------------------------------------
module pcm_eval (
   input  logic                           clock,
   input  pcm_pkg::pcm_scan_type          scan,
   input  pcm_pkg::pcm_entry_type         entry,
   input  logic [pcm_pkg::CODE_BITS-1:0]  key,
   input  logic [pcm_pkg::CODE_BITS-1:0]  width_mask,
   output pcm_pkg::pcm_pick_type          pick
);
   import pcm_pkg::*;

   logic              ex_found_ff, ex_found_in;
   logic [IDX_W-1:0]  ex_idx_ff, ex_idx_in;
   logic              ex_inv_ff, ex_inv_in;
   logic [COST_W-1:0] minc_ff, minc_in;
   logic [IDX_W-1:0]  nr_idx_ff, nr_idx_in;
   logic [DIST_W-1:0] nr_dist_ff, nr_dist_in;
   logic [COST_W-1:0] nr_cost_ff, nr_cost_in;
   logic              nr_inv_ff, nr_inv_in;

   logic [CODE_BITS-1:0] fix_mask;
   logic [CODE_BITS-1:0] kplain;
   logic [CODE_BITS-1:0] kinv;
   logic [DIST_W-1:0]    d_plain;
   logic [DIST_W-1:0]    d_inv;
   logic [DIST_W-1:0]    d_best;
   logic                 d_use_inv;
   logic                 code_hit;
   logic                 ex_base_found;
   logic [COST_W-1:0]    ex_base_minc;
   logic [COST_W:0]      cost_sum;

   // the entry's fixed bit drops out of the distance; out of range drops none
   always_comb begin
      for (int b = 0; b < CODE_BITS; b++) begin
         fix_mask[b] = (entry.fixed != FIX_W'(b));
      end
   end

   assign kplain    = key & width_mask;
   assign kinv      = ~key & width_mask;
   assign code_hit  = (entry.code == kplain) || (entry.code == kinv);
   assign d_plain   = DIST_W'($countones((entry.code ^ key) & width_mask & fix_mask));
   assign d_inv     = DIST_W'($countones((entry.code ^ ~key) & width_mask & fix_mask));
   assign d_use_inv = d_inv < d_plain;
   assign d_best    = d_use_inv ? d_inv : d_plain;

   // running minimum starts at entry 0's cost
   assign ex_base_found = scan.first ? 1'b0 : ex_found_ff;
   assign ex_base_minc  = scan.first ? entry.cost : minc_ff;

   always_comb begin
      ex_found_in = ex_found_ff;
      ex_idx_in   = ex_idx_ff;
      ex_inv_in   = ex_inv_ff;
      minc_in     = minc_ff;
      nr_idx_in   = nr_idx_ff;
      nr_dist_in  = nr_dist_ff;
      nr_cost_in  = nr_cost_ff;
      nr_inv_in   = nr_inv_ff;
      if (scan.valid) begin
         ex_found_in = ex_base_found;
         minc_in     = ex_base_minc;
         if (code_hit && (entry.cost <= ex_base_minc)) begin
            ex_found_in = 1'b1;
            ex_idx_in   = scan.index;
            ex_inv_in   = (entry.code != kplain);
            minc_in     = entry.cost;
         end
         // later entry wins ties at lower or equal cost
         if (scan.first || (d_best < nr_dist_ff) ||
             ((d_best == nr_dist_ff) && (nr_cost_ff >= entry.cost))) begin
            nr_idx_in  = scan.index;
            nr_dist_in = d_best;
            nr_cost_in = entry.cost;
            nr_inv_in  = d_use_inv;
         end
      end
   end

   always_ff @(posedge clock) begin
      ex_found_ff <= ex_found_in;
      ex_idx_ff   <= ex_idx_in;
      ex_inv_ff   <= ex_inv_in;
      minc_ff     <= minc_in;
      nr_idx_ff   <= nr_idx_in;
      nr_dist_ff  <= nr_dist_in;
      nr_cost_ff  <= nr_cost_in;
      nr_inv_ff   <= nr_inv_in;
   end

   assign cost_sum = (COST_W+1)'(nr_cost_ff) + (COST_W+1)'(nr_dist_ff);

   always_comb begin
      if (ex_found_ff) begin
         pick.exact      = 1'b1;
         pick.index      = ex_idx_ff;
         pick.inverse    = ex_inv_ff;
         pick.distance   = '0;
         pick.total_cost = minc_ff;
      end else begin
         pick.exact      = 1'b0;
         pick.index      = nr_idx_ff;
         pick.inverse    = nr_inv_ff;
         pick.distance   = nr_dist_ff;
         pick.total_cost = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
      end
   end

endmodule

// File: sv/partition_code_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partition_code_matcher
// Table of partition entries with exact and nearest code lookup.
// ----------------------------------------------------------------------------
// Clear, append and reserved items: result in the cycle after accept, busy stays
// low, so one item per cycle.
// Query: one table read per cycle in ST_SCAN through the single memory read
// port, then ST_DRAIN and ST_FINISH; a query on an empty table answers in the
// cycle after accept. Results cannot be stalled by the receiver.
// Reset empties the table and clears code_width; no memory clearing pass.
module partition_code_matcher (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  pcm_pkg::pcm_req_type req_item,
   output logic                 rsp_strobe,
   output pcm_pkg::pcm_rsp_type rsp_item,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import pcm_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CW_W-1:0]      code_width_ff;
   logic [CODE_BITS-1:0] key_ff, key_in;
   logic [CODE_BITS-1:0] mask_ff, mask_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic [IDX_W-1:0]     rd_ptr_ff, rd_ptr_in;
   pcm_scan_type         scan_ff, scan_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   pcm_rsp_type          rsp_item_ff, rsp_item_in;

   logic          accept;
   logic          csr_write;
   logic          wr_en;
   pcm_entry_type wr_entry;
   pcm_entry_type rd_entry;
   pcm_pick_type  pick;
   logic          scan_last;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == 1'b0) ? 32'(code_width_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_width_ff <= '0;
      end else if (csr_write && (paddr[2] == 1'b0)) begin
         code_width_ff <= pwdata[CW_W-1:0];
      end
   end

   // low code_width bits count; any width past the code covers all bits
   always_comb begin
      for (int b = 0; b < CODE_BITS; b++) begin
         mask_in[b] = (code_width_ff > CW_W'(b));
      end
   end

   assign wr_entry.code  = req_item.entry_code[CODE_BITS-1:0];
   assign wr_entry.cost  = req_item.entry_cost;
   assign wr_entry.fixed = req_item.fixed_bit;
   assign scan_last      = (CNT_W'(rd_ptr_ff) + CNT_W'(1)) == count_ff;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      tag_in        = tag_ff;
      rd_ptr_in     = rd_ptr_ff;
      scan_in       = '0;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      wr_en         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_item_in = '0;
               case (req_item.req_type)
                  REQ_CLEAR: begin
                     count_in      = '0;
                     rsp_strobe_in = 1'b1;
                  end
                  REQ_APPEND: begin
                     // drop the entry when the table is full
                     if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                     rsp_strobe_in = 1'b1;
                  end
                  REQ_QUERY: begin
                     key_in    = req_item.query_key[CODE_BITS-1:0];
                     tag_in    = req_item.query_tag;
                     rd_ptr_in = '0;
                     if (count_ff == '0) begin
                        rsp_strobe_in        = 1'b1;
                        rsp_item_in.tag_out = req_item.query_tag;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            scan_in.valid = 1'b1;
            scan_in.first = (rd_ptr_ff == '0);
            scan_in.index = rd_ptr_ff;
            rd_ptr_in     = rd_ptr_ff + IDX_W'(1);
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last entry is evaluated this cycle
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_strobe_in            = 1'b1;
            rsp_item_in.tag_out      = tag_ff;
            rsp_item_in.found        = 1'b1;
            rsp_item_in.match_index  = MIDX_W'(pick.index);
            rsp_item_in.inverse      = pick.inverse;
            rsp_item_in.exact        = pick.exact;
            rsp_item_in.distance     = pick.distance;
            rsp_item_in.total_cost   = pick.total_cost;
            state_in                 = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         scan_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         scan_ff       <= scan_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      tag_ff      <= tag_in;
      rd_ptr_ff   <= rd_ptr_in;
      rsp_item_ff <= rsp_item_in;
      if (accept) begin
         mask_ff <= mask_in;
      end
   end

   pcm_ram #(
      .WIDTH ($bits(pcm_entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_entry)
   );

   pcm_eval u_eval (
      .clock      (clock),
      .scan       (scan_ff),
      .entry      (rd_entry),
      .key        (key_ff),
      .width_mask (mask_ff),
      .pick       (pick)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

// File: dv/pcm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_checker
// Watches the item, result and register ports of the partition code matcher.
// It keeps its own copy of the entry table and of code_width, works out the
// result of every accepted item and compares each result with the oldest one
// still due. Mismatches go to fail_count.
// ----------------------------------------------------------------------------
module pcm_checker #(
   parameter logic [2:0] WIDTH_ADDR = '0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  pcm_pkg::pcm_req_type req_item,
   input  logic                 rsp_strobe,
   input  pcm_pkg::pcm_rsp_type rsp_item,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   input  logic [31:0]          prdata,
   input  logic                 pready,
   output int                   fail_count,
   output int                   pending_count
);
   import pcm_pkg::*;

   logic [CODE_BITS-1:0] code_mem [TABLE_DEPTH];
   logic [COST_W-1:0]    cost_mem [TABLE_DEPTH];
   logic [FIX_W-1:0]     fix_mem  [TABLE_DEPTH];
   int                   entry_cnt;
   logic [CW_W-1:0]      width_reg;
   pcm_rsp_type          rsp_due_q [$];
   pcm_rsp_type          oldest_due;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      entry_cnt     = 0;
      width_reg     = '0;
   end

   // Apply one item to the table copy and return the result it must produce.
   function automatic pcm_rsp_type match_item(input pcm_req_type it);
      pcm_rsp_type          r;
      logic [CODE_BITS-1:0] wmask;
      logic [CODE_BITS-1:0] kplain;
      logic [CODE_BITS-1:0] kinv;
      logic [CODE_BITS-1:0] fmask;
      logic [COST_W-1:0]    min_cost;
      logic [COST_W-1:0]    best_cost;
      logic [COST_W:0]      sum;
      int                   best_d;
      int                   d_plain;
      int                   d_inv;
      int                   d;
      int                   sel;
      logic                 hit;
      logic                 inv;
      logic                 use_inv;
      r = '0;
      case (it.req_type)
         REQ_CLEAR: entry_cnt = 0;
         REQ_APPEND: begin
            // drop appends to a full table
            if (entry_cnt < TABLE_DEPTH) begin
               code_mem[entry_cnt] = it.entry_code;
               cost_mem[entry_cnt] = it.entry_cost;
               fix_mem[entry_cnt]  = it.fixed_bit;
               entry_cnt++;
            end
         end
         REQ_QUERY: begin
            r.tag_out = it.query_tag;
            if (entry_cnt > 0) begin
               wmask = '1;
               if (width_reg < CODE_BITS)
                  wmask = wmask >> (CODE_BITS - width_reg);
               kplain   = it.query_key & wmask;
               kinv     = ~it.query_key & wmask;
               min_cost = cost_mem[0];
               hit      = 1'b0;
               sel      = 0;
               inv      = 1'b0;
               // exact pass: later entry wins on equal cost
               for (int i = 0; i < entry_cnt; i++) begin
                  if ((code_mem[i] == kplain || code_mem[i] == kinv) &&
                      cost_mem[i] <= min_cost) begin
                     hit      = 1'b1;
                     sel      = i;
                     min_cost = cost_mem[i];
                     inv      = (code_mem[i] != kplain);
                  end
               end
               if (hit) begin
                  r.exact      = 1'b1;
                  r.distance   = '0;
                  r.total_cost = min_cost;
               end else begin
                  best_d    = 0;
                  best_cost = '0;
                  for (int i = 0; i < entry_cnt; i++) begin
                     fmask = '1;
                     if (fix_mem[i] < CODE_BITS)
                        fmask[fix_mem[i][$clog2(CODE_BITS)-1:0]] = 1'b0;
                     d_plain = $countones((code_mem[i] ^ it.query_key) & wmask & fmask);
                     d_inv   = $countones((code_mem[i] ^ ~it.query_key) & wmask & fmask);
                     d       = d_plain;
                     use_inv = 1'b0;
                     if (d_inv < d_plain) begin
                        d       = d_inv;
                        use_inv = 1'b1;
                     end
                     if (!hit || d < best_d || (d == best_d && best_cost >= cost_mem[i])) begin
                        hit       = 1'b1;
                        best_d    = d;
                        best_cost = cost_mem[i];
                        sel       = i;
                        inv       = use_inv;
                     end
                  end
                  sum          = {1'b0, best_cost} + (COST_W + 1)'(best_d);
                  r.distance   = DIST_W'(best_d);
                  r.total_cost = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
               end
               r.found       = 1'b1;
               r.match_index = MIDX_W'(sel);
               r.inverse     = inv;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         entry_cnt = 0;
         width_reg = '0;
         rsp_due_q.delete();
      end else begin
         // retire the result before queuing a newly accepted item
         if (rsp_strobe) begin
            if (rsp_due_q.size() == 0) begin
               $error("result with no item waiting");
               fail_count++;
            end else begin
               oldest_due = rsp_due_q.pop_front();
               check_field("tag_out", 32'(oldest_due.tag_out), 32'(rsp_item.tag_out));
               check_field("found", 32'(oldest_due.found), 32'(rsp_item.found));
               check_field("match_index", 32'(oldest_due.match_index),
                           32'(rsp_item.match_index));
               check_field("inverse", 32'(oldest_due.inverse), 32'(rsp_item.inverse));
               check_field("exact", 32'(oldest_due.exact), 32'(rsp_item.exact));
               check_field("distance", 32'(oldest_due.distance), 32'(rsp_item.distance));
               check_field("total_cost", 32'(oldest_due.total_cost),
                           32'(rsp_item.total_cost));
            end
         end
         if (start && !busy)
            rsp_due_q.insert(rsp_due_q.size(), match_item(req_item));
         if (psel && penable && pready && paddr == WIDTH_ADDR) begin
            if (pwrite)
               width_reg = pwdata[CW_W-1:0];
            else
               check_field("code_width", 32'(width_reg), 32'(prdata[CW_W-1:0]));
         end
      end
      pending_count <= rsp_due_q.size();
   end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the partition code matcher. A short directed run
// covers the empty table, exact matches on key and complement, a rejected
// exact match, excluded bits, cost saturation and the reserved item; then
// random phases change code_width, clear and fill the table (now and then
// past full) and query it with keys near the stored codes.
// ----------------------------------------------------------------------------
module tb;
   import pcm_pkg::*;

   localparam logic [2:0] CSR_CODE_WIDTH = 3'd0;
   localparam logic [1:0] REQ_RESERVED   = 2'd3;
   localparam int         RAND_ITEMS     = 1000;
   localparam int         CALM_ITEMS     = 100;
   localparam int         CYCLE_LIMIT    = 500000;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   pcm_req_type req_item;
   logic        rsp_strobe;
   pcm_rsp_type rsp_item;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int                fail_count;
   int                pending_count;
   int                cycle_count = 0;
   int                items_sent  = 0;
   bit                gaps_on     = 1'b0;
   logic [CW_W-1:0]   cur_width   = '0;
   logic [KEY_W-1:0]  stored_codes [$];

   partition_code_matcher u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   pcm_checker #(.WIDTH_ADDR(CSR_CODE_WIDTH)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_strobe    (rsp_strobe),
      .rsp_item      (rsp_item),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic pcm_req_type rand_item(input logic [1:0] kind);
      pcm_req_type it;
      it.req_type   = kind;
      it.entry_code = KEY_W'($urandom);
      it.entry_cost = COST_W'($urandom);
      it.fixed_bit  = FIX_W'($urandom);
      it.query_tag  = TAG_W'($urandom);
      it.query_key  = KEY_W'($urandom);
      return it;
   endfunction

   task automatic send_item(input pcm_req_type it);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      items_sent++;
      // track stored codes so queries can aim near them
      case (it.req_type)
         REQ_CLEAR: stored_codes.delete();
         REQ_APPEND: begin
            if (stored_codes.size() < TABLE_DEPTH)
               stored_codes.insert(stored_codes.size(), it.entry_code);
         end
         default: ;
      endcase
   endtask

   task automatic append_entry(input logic [KEY_W-1:0] code, input logic [COST_W-1:0] cost,
                               input logic [FIX_W-1:0] fix);
      pcm_req_type it;
      it            = rand_item(REQ_APPEND);
      it.entry_code = code;
      it.entry_cost = cost;
      it.fixed_bit  = fix;
      send_item(it);
   endtask

   task automatic query_with(input logic [KEY_W-1:0] key, input logic [TAG_W-1:0] tag);
      pcm_req_type it;
      it           = rand_item(REQ_QUERY);
      it.query_key = key;
      it.query_tag = tag;
      send_item(it);
   endtask

   task automatic append_random();
      logic [KEY_W-1:0]  code;
      logic [COST_W-1:0] cost;
      logic [FIX_W-1:0]  fix;
      code = KEY_W'($urandom);
      case ($urandom_range(0, 4))
         0: ;
         1: if (stored_codes.size() > 0)
               code = stored_codes[$urandom_range(0, stored_codes.size() - 1)];
         2: code = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
         // keep the code inside the current width so exact hits happen
         default: code = code & ~(16'hFFFF << cur_width);
      endcase
      case ($urandom_range(0, 9))
         0, 1: cost = COST_W'($urandom);
         2: cost = COST_MAX - COST_W'($urandom_range(0, 3));
         default: cost = COST_W'($urandom_range(0, 3));
      endcase
      fix = ($urandom_range(0, 3) == 0) ? FIX_W'($urandom) : FIX_W'($urandom_range(0, 16));
      append_entry(code, cost, fix);
   endtask

   // Hold the sender until every result is back and the block is idle.
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_count != 0 || busy) @(negedge clock);
   endtask

   task automatic set_code_width(input logic [CW_W-1:0] w);
      wait_drained();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_CODE_WIDTH;
      pwdata  <= {27'd0, w};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      // read it back
      @(negedge clock);
      psel    <= 1'b1;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      cur_width = w;
   endtask

   initial begin
      int               target;
      int               n_app;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] base;
      logic [CW_W-1:0]  w;
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part
      query_with(16'hA5A5, 6'd0);
      send_item(rand_item(REQ_RESERVED));
      set_code_width(5'd16);
      append_entry(16'h0000, 16'd5, 5'd16);
      append_entry(16'hFFFF, 16'hFFFF, 5'd0);
      append_entry(16'h1234, 16'd3, 5'd15);
      append_entry(16'h1234, 16'd3, 5'd31);
      append_entry(16'hEDCB, 16'd3, 5'd4);
      query_with(16'h1234, 6'd63);
      query_with(16'h0000, 6'd1);
      query_with(16'h0001, 6'd2);
      query_with(16'hFFFE, 6'd3);
      query_with(16'h1235, 6'd4);
      // exact code present but dearer than entry 0: falls back to nearest
      send_item(rand_item(REQ_CLEAR));
      append_entry(16'h00FF, 16'd1, 5'd16);
      append_entry(16'h0F0F, 16'd9, 5'd16);
      query_with(16'h0F0F, 6'd5);
      // cost saturates
      send_item(rand_item(REQ_CLEAR));
      append_entry(16'hFFFF, 16'hFFFF, 5'd16);
      query_with(16'h00F0, 6'd6);

      // random phases
      target = items_sent + RAND_ITEMS;
      while (items_sent < target) begin
         gaps_on = (items_sent < target - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 9))
               0: w = 5'd0;
               1: w = 5'd31;
               2: w = 5'd16;
               3: w = CW_W'($urandom_range(17, 30));
               default: w = CW_W'($urandom_range(1, 15));
            endcase
            set_code_width(w);
         end
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(5, 20)) send_item(rand_item(2'($urandom)));
         end else begin
            if ($urandom_range(0, 4) != 0)
               send_item(rand_item(REQ_CLEAR));
            n_app = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 72)
                                                 : $urandom_range(0, 10);
            repeat (n_app) append_random();
            repeat ($urandom_range(1, 10)) begin
               case ($urandom_range(0, 9))
                  0: append_random();
                  1: send_item(rand_item(REQ_RESERVED));
                  default: begin
                     key = KEY_W'($urandom);
                     if (stored_codes.size() > 0 && $urandom_range(0, 3) != 0) begin
                        base = stored_codes[$urandom_range(0, stored_codes.size() - 1)];
                        case ($urandom_range(0, 3))
                           0: key = base;
                           1: key = ~base;
                           2: key = base ^ (16'd1 << $urandom_range(0, 15));
                           default: key = ~base ^ (16'd1 << $urandom_range(0, 15))
                                                ^ (16'd1 << $urandom_range(0, 15));
                        endcase
                     end
                     query_with(key, TAG_W'($urandom));
                  end
               endcase
            end
         end
      end

      gaps_on = 1'b0;
      wait_drained();
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: filelist.f
sv/pcm_pkg.sv
sv/pcm_ram.sv
sv/pcm_eval.sv
sv/partition_code_matcher.sv
dv/pcm_checker.sv
dv/tb.sv
